### rtl/qeb_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature encoder with button: shared package
// Widths, request codes, event codes and phase helpers used across the block.
// ----------------------------------------------------------------------------
package qeb_pkg;

  // Width of the wrapping turn counter and of the saturating press counter.
  localparam int TURN_BITS  = 16;
  localparam int PRESS_BITS = 16;

  // Widths fixed by the external fields.
  localparam int ACTION_BITS = 2;
  localparam int COUNT_BITS  = 16;
  localparam int EVENT_BITS  = 2;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 1;

  // Compare width for the press counter against the thresholds.
  localparam int CMP_BITS = (PRESS_BITS > CFG_BITS) ? PRESS_BITS : CFG_BITS;
  // Working width for sign extension of the turn count.
  localparam int EXT_BITS = TURN_BITS + COUNT_BITS;

  localparam logic [PRESS_BITS-1:0] PRESS_MAX = {PRESS_BITS{1'b1}};

  // Reset values of the threshold registers.
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(50);
  localparam logic [CFG_BITS-1:0] LONG_CLICK_RESET = CFG_BITS'(1000);

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_CLICK = 1'b1;

  // Request codes.
  localparam logic [ACTION_BITS-1:0] ACT_TICK       = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_READ_TURNS = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_READ_EVENT = 2'd2;

  // Button event codes.
  localparam logic [EVENT_BITS-1:0] EVT_NONE  = 2'd0;
  localparam logic [EVENT_BITS-1:0] EVT_CLICK = 2'd1;
  localparam logic [EVENT_BITS-1:0] EVT_LONG  = 2'd2;

  // One request as held in the input register.
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic                   phase_a_level;
    logic                   phase_b_level;
    logic                   switch_level;
  } qeb_item_t;

  // Result of one request, with a flag for whether it produces one.
  typedef struct packed {
    logic                         has_result;
    logic signed [COUNT_BITS-1:0] turn_count;
    logic [EVENT_BITS-1:0]        button_event;
  } qeb_result_t;

  // Next phase in the forward order 00 -> 10 -> 11 -> 01 -> 00.
  function automatic logic [1:0] fwd_next(input logic [1:0] prev);
    logic [1:0] nxt;
    unique case (prev)
      2'b00:   nxt = 2'b10;
      2'b01:   nxt = 2'b00;
      2'b10:   nxt = 2'b11;
      default: nxt = 2'b01;
    endcase
    return nxt;
  endfunction

  // Next phase in the backward order.
  function automatic logic [1:0] back_next(input logic [1:0] prev);
    logic [1:0] nxt;
    unique case (prev)
      2'b00:   nxt = 2'b01;
      2'b01:   nxt = 2'b11;
      2'b10:   nxt = 2'b00;
      default: nxt = 2'b10;
    endcase
    return nxt;
  endfunction

  // Sign extend the turn counter, then keep the low bits of the output field.
  function automatic logic [COUNT_BITS-1:0] turns_out(input logic signed [TURN_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[COUNT_BITS-1:0];
  endfunction

endpackage

### rtl/quadrature_encoder_with_button.sv
// ----------------------------------------------------------------------------
// Path: an accepted read request goes from the input register through the state
// unit into the result register, with out_valid high, unless a stall holds it.
// Throughput: one request per cycle, limited only by the result register
// being held by out_stall while a read request waits behind it.
// Reset: synchronous, active high; thresholds return to 50 and 1000 ticks,
// all counters, the phase and the pending event clear.
// ----------------------------------------------------------------------------
// Quadrature encoder with button: top level
// Input register, state unit and result register for the encoder and button.
// ----------------------------------------------------------------------------
module quadrature_encoder_with_button (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [qeb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [qeb_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [qeb_pkg::ACTION_BITS-1:0]      action,
  input  logic                                 phase_a_level,
  input  logic                                 phase_b_level,
  input  logic                                 switch_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qeb_pkg::COUNT_BITS-1:0] turn_count,
  output logic [qeb_pkg::EVENT_BITS-1:0]       button_event
);
  import qeb_pkg::*;

  logic        s_valid;
  qeb_item_t   s_item;
  qeb_result_t res;
  logic        blocked;
  logic        step_en;

  // A request with a result waits while the result register is held.
  assign blocked  = res.has_result && out_valid && out_stall;
  assign step_en  = s_valid && !blocked;
  assign in_stall = s_valid && blocked;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item.action        <= action;
      s_item.phase_a_level <= phase_a_level;
      s_item.phase_b_level <= phase_b_level;
      s_item.switch_level  <= switch_level;
    end
  end

  qeb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (step_en),
    .item      (s_item),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && res.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.has_result) begin
      turn_count   <= res.turn_count;
      button_event <= res.button_event;
    end
  end

  // A tick never waits on the result side.
  a_tick_not_blocked: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_item.action == ACT_TICK |-> !in_stall)
    else $error("tick request blocked");

  // An empty input register never stalls the sender.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> !in_stall)
    else $error("stall raised with an empty input register");

  // A read that steps forward always shows a result at the next edge.
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    step_en && res.has_result |=> out_valid)
    else $error("read request lost its result");

endmodule

### rtl/qeb_core.sv
// ----------------------------------------------------------------------------
// Quadrature encoder with button: state unit
// Holds the thresholds, phase, turn and press state and applies one request
// per enabled cycle; the result is formed from the state before the update.
// ----------------------------------------------------------------------------
module qeb_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [qeb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [qeb_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             step_en,
  input  qeb_pkg::qeb_item_t               item,
  output qeb_pkg::qeb_result_t             res
);
  import qeb_pkg::*;

  logic [CFG_BITS-1:0]          debounce_ticks;
  logic [CFG_BITS-1:0]          long_click_ticks;
  logic [1:0]                   last_phase;
  logic [1:0]                   last_phase_next;
  logic                         phase_captured;
  logic                         phase_captured_next;
  logic signed [TURN_BITS-1:0]  step_total;
  logic signed [TURN_BITS-1:0]  step_total_next;
  logic [PRESS_BITS-1:0]        press_ticks;
  logic [PRESS_BITS-1:0]        press_ticks_next;
  logic [EVENT_BITS-1:0]        pending_event;
  logic [EVENT_BITS-1:0]        pending_event_next;
  logic [1:0]                   cur_phase;
  logic [CMP_BITS-1:0]          press_cmp;

  // Phases are active low; A sits in the upper bit.
  assign cur_phase = {~item.phase_a_level, ~item.phase_b_level};
  assign press_cmp = CMP_BITS'(press_ticks);

  // Result of a read request, taken from the state before this request.
  always_comb begin
    res.has_result   = 1'b0;
    res.turn_count   = '0;
    res.button_event = EVT_NONE;
    unique case (item.action)
      ACT_READ_TURNS: begin
        res.has_result = 1'b1;
        res.turn_count = turns_out(step_total);
      end
      ACT_READ_EVENT: begin
        res.has_result   = 1'b1;
        res.button_event = pending_event;
      end
      default: begin
        res.has_result = 1'b0;
      end
    endcase
  end

  // Next state for one request.
  always_comb begin
    last_phase_next     = last_phase;
    phase_captured_next = phase_captured;
    step_total_next     = step_total;
    press_ticks_next    = press_ticks;
    pending_event_next  = pending_event;
    unique case (item.action)
      ACT_TICK: begin
        // Phase tracking: the first tick after reset only captures the phase.
        if (!phase_captured) begin
          last_phase_next     = cur_phase;
          phase_captured_next = 1'b1;
        end else if (cur_phase != last_phase) begin
          if (fwd_next(last_phase) == cur_phase) begin
            step_total_next = step_total + TURN_BITS'(1);
          end else if (back_next(last_phase) == cur_phase) begin
            step_total_next = step_total - TURN_BITS'(1);
          end
          last_phase_next = cur_phase;
        end
        // Button: count while held, classify on release.
        if (!item.switch_level) begin
          if (press_ticks != PRESS_MAX) begin
            press_ticks_next = press_ticks + PRESS_BITS'(1);
          end
        end else if (press_ticks != '0) begin
          if (press_cmp >= CMP_BITS'(long_click_ticks)) begin
            pending_event_next = EVT_LONG;
          end else if (press_cmp >= CMP_BITS'(debounce_ticks)) begin
            pending_event_next = EVT_CLICK;
          end
          press_ticks_next = '0;
        end
      end
      ACT_READ_TURNS: begin
        step_total_next = '0;
      end
      ACT_READ_EVENT: begin
        pending_event_next = EVT_NONE;
      end
      default: begin
        step_total_next = step_total;
      end
    endcase
  end

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_click_ticks <= LONG_CLICK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        default:        long_click_ticks <= cfg_data;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase     <= '0;
      phase_captured <= 1'b0;
      step_total     <= '0;
      press_ticks    <= '0;
      pending_event  <= EVT_NONE;
    end else if (step_en) begin
      last_phase     <= last_phase_next;
      phase_captured <= phase_captured_next;
      step_total     <= step_total_next;
      press_ticks    <= press_ticks_next;
      pending_event  <= pending_event_next;
    end
  end

  // A turn read leaves the counter at zero.
  a_read_clears_turns: assert property (@(posedge clk) disable iff (rst)
    step_en && item.action == ACT_READ_TURNS |=> step_total == '0)
    else $error("turn counter not cleared by a read");

  // A tick with the button released leaves the press counter at zero.
  a_release_clears_press: assert property (@(posedge clk) disable iff (rst)
    step_en && item.action == ACT_TICK && item.switch_level |=> press_ticks == '0)
    else $error("press counter not cleared on release");

  // The pending event never holds an undefined code.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    pending_event == EVT_NONE || pending_event == EVT_CLICK || pending_event == EVT_LONG)
    else $error("pending event holds an undefined code");

endmodule
